FILE: hdl/npca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npca_pkg
// Shared constants, types and helpers for the nearest palette color
// attribute encoder: palette table, field widths, lane records.
// ----------------------------------------------------------------------------
package npca_pkg;

	localparam int NUM_COLORS = 16;
	localparam int NUM_SRC    = 2;   // foreground, background
	localparam int IDX_W      = 4;
	localparam int COLOR_W    = 24;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 10;  // r + g + b up to 765
	localparam int SQ_W       = 16;  // channel difference squared
	localparam int SSQ_W      = 18;  // sum difference squared, divided by four
	localparam int DIST_W     = 19;  // largest distance 341381
	localparam int ATTR_W     = 8;

	localparam int SRC_FG = 0;
	localparam int SRC_BG = 1;

	// index order is intensity, red, green, blue
	localparam logic [COLOR_W-1:0] PALETTE [NUM_COLORS] = '{
		24'h0F1419, 24'h007ACC, 24'h6A9955, 24'h4EC9B0,
		24'hCE9178, 24'hC586C0, 24'hD7BA7D, 24'hD4D4D4,
		24'h5C6773, 24'h569CD6, 24'hB5CEA8, 24'h39BAE6,
		24'hF44747, 24'hD4BFFF, 24'hFFD700, 24'hFFFFFF
	};

	typedef struct packed {
		logic [CH_W-1:0]  dr;
		logic [CH_W-1:0]  dg;
		logic [CH_W-1:0]  db;
		logic [SUM_W-1:0] ds;
	} diff_t;

	typedef struct packed {
		logic [SQ_W-1:0]  sr;
		logic [SQ_W-1:0]  sg;
		logic [SQ_W-1:0]  sb;
		logic [SSQ_W-1:0] ss;
	} sq_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
	} cand_t;

	function automatic logic [SUM_W-1:0] chan_sum(input logic [COLOR_W-1:0] rgb);
		logic [SUM_W-1:0] s;
		s = SUM_W'(rgb[23:16]) + SUM_W'(rgb[15:8]) + SUM_W'(rgb[7:0]);
		return s;
	endfunction

	function automatic logic [CH_W-1:0] abs_diff8(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a >= b) ? a - b : b - a;
		return d;
	endfunction

	function automatic logic [SUM_W-1:0] abs_diff10(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] d;
		d = (a >= b) ? a - b : b - a;
		return d;
	endfunction

	// a is always the lower index, so it keeps ties
	function automatic cand_t min2(input cand_t a, input cand_t b);
		cand_t m;
		m = (b.distance < a.distance) ? b : a;
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/nearest_palette_color_attr_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_attr_top
// Maps a foreground and background RGB color to the nearest entries of a
// fixed 16-color palette and packs both indices into one attribute byte.
// ----------------------------------------------------------------------------
//  channel    | direction | handshake                       | payload
//  color      | in        | color_valid / color_ready       | fg_color, bg_color
//  attribute  | out       | attribute_valid / attribute_ready | attribute
//
//  five register stages: differences, squares, distance sum, 16-to-4 minimum,
//  4-to-1 minimum; the last stage is the output register
//  one transfer per cycle sustained in each direction while attribute_ready stays high
//  reset clears only the stage valid bits
//  each stage has its own ready, so a stall fills bubbles and drops nothing
// ----------------------------------------------------------------------------
module nearest_palette_color_attr_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           color_valid,
	output logic                          color_ready,
	input  wire  [npca_pkg::COLOR_W-1:0]  fg_color,
	input  wire  [npca_pkg::COLOR_W-1:0]  bg_color,
	output logic                          attribute_valid,
	input  wire                           attribute_ready,
	output logic [npca_pkg::ATTR_W-1:0]   attribute
);
	import npca_pkg::*;

	localparam int GRP = 4;
	localparam int NUM_GRP = NUM_COLORS / GRP;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	diff_t  diff_s1 [NUM_SRC][NUM_COLORS];
	sq_t    sq_s2   [NUM_SRC][NUM_COLORS];
	cand_t  cand_s3 [NUM_SRC][NUM_COLORS];
	cand_t  best_s4 [NUM_SRC][NUM_GRP];
	logic [ATTR_W-1:0] attr_s5;

	diff_t  diff_d [NUM_SRC][NUM_COLORS];
	sq_t    sq_d   [NUM_SRC][NUM_COLORS];
	cand_t  cand_d [NUM_SRC][NUM_COLORS];
	cand_t  best_d [NUM_SRC][NUM_GRP];
	logic [IDX_W-1:0] win_d [NUM_SRC];

	// ready runs back from the output so empty stages still advance
	assign rdy5 = !v_s5 || attribute_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign color_ready = rdy1;

	assign attribute_valid = v_s5;
	assign attribute = attr_s5;

	// stage 1: channel and sum differences against every palette entry
	always_comb begin
		logic [COLOR_W-1:0] col;
		logic [SUM_W-1:0]   s;
		for (int c = 0; c < NUM_SRC; c++) begin
			col = (c == SRC_BG) ? bg_color : fg_color;
			s = chan_sum(col);
			for (int i = 0; i < NUM_COLORS; i++) begin
				diff_d[c][i].dr = abs_diff8(col[23:16], PALETTE[i][23:16]);
				diff_d[c][i].dg = abs_diff8(col[15:8], PALETTE[i][15:8]);
				diff_d[c][i].db = abs_diff8(col[7:0], PALETTE[i][7:0]);
				diff_d[c][i].ds = abs_diff10(s, chan_sum(PALETTE[i]));
			end
		end
	end

	// stage 2: squares
	always_comb begin
		logic [2*SUM_W-1:0] ssq;
		for (int c = 0; c < NUM_SRC; c++) begin
			for (int i = 0; i < NUM_COLORS; i++) begin
				sq_d[c][i].sr = SQ_W'(diff_s1[c][i].dr) * SQ_W'(diff_s1[c][i].dr);
				sq_d[c][i].sg = SQ_W'(diff_s1[c][i].dg) * SQ_W'(diff_s1[c][i].dg);
				sq_d[c][i].sb = SQ_W'(diff_s1[c][i].db) * SQ_W'(diff_s1[c][i].db);
				ssq = (2*SUM_W)'(diff_s1[c][i].ds) * (2*SUM_W)'(diff_s1[c][i].ds);
				sq_d[c][i].ss = ssq[2*SUM_W-1:2];
			end
		end
	end

	// stage 3: distance
	always_comb begin
		for (int c = 0; c < NUM_SRC; c++) begin
			for (int i = 0; i < NUM_COLORS; i++) begin
				cand_d[c][i].distance = DIST_W'(sq_s2[c][i].sr)
					+ DIST_W'(sq_s2[c][i].sg)
					+ DIST_W'(sq_s2[c][i].sb) + DIST_W'(sq_s2[c][i].ss);
				cand_d[c][i].idx = IDX_W'(i);
			end
		end
	end

	// stage 4: minimum within each group of four, lower index first
	always_comb begin
		for (int c = 0; c < NUM_SRC; c++) begin
			for (int g = 0; g < NUM_GRP; g++) begin
				best_d[c][g] = min2(
					min2(cand_s3[c][g*GRP], cand_s3[c][g*GRP+1]),
					min2(cand_s3[c][g*GRP+2], cand_s3[c][g*GRP+3]));
			end
		end
	end

	// stage 5: minimum over the groups
	always_comb begin
		cand_t w;
		for (int c = 0; c < NUM_SRC; c++) begin
			w = min2(min2(best_s4[c][0], best_s4[c][1]),
				min2(best_s4[c][2], best_s4[c][3]));
			win_d[c] = w.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= color_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && color_valid) diff_s1 <= diff_d;
		if (rdy2 && v_s1) sq_s2 <= sq_d;
		if (rdy3 && v_s2) cand_s3 <= cand_d;
		if (rdy4 && v_s3) best_s4 <= best_d;
		if (rdy5 && v_s4) attr_s5 <= {win_d[SRC_BG], win_d[SRC_FG]};
	end

endmodule
`default_nettype wire

FILE: hdl/npca_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npca_checker
// Port-level checks for the palette attribute encoder: occupancy, ready with
// room, no output from an empty pipeline and output hold, bound to the top level.
// ----------------------------------------------------------------------------
module npca_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          color_valid,
	input wire                          color_ready,
	input wire                          attribute_valid,
	input wire                          attribute_ready,
	input wire [npca_pkg::ATTR_W-1:0]   attribute
);
	import npca_pkg::*;

	localparam int DEPTH = 5;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic in_xfer, out_xfer;

	assign in_xfer = color_valid && color_ready;
	assign out_xfer = attribute_valid && attribute_ready;

	// items inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		attribute_valid && !attribute_ready |=> attribute_valid && $stable(attribute))
		else $error("attribute dropped or changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		attribute_valid |-> cnt_q != '0)
		else $error("attribute transfer without a pending color");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(DEPTH) |-> color_ready)
		else $error("color not accepted although the pipeline has room");

	a_empty_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 && !in_xfer |=> !attribute_valid)
		else $error("attribute valid from an empty pipeline");

endmodule

bind nearest_palette_color_attr_top npca_checker u_npca_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.color_valid     (color_valid),
	.color_ready     (color_ready),
	.attribute_valid (attribute_valid),
	.attribute_ready (attribute_ready),
	.attribute       (attribute)
);
`default_nettype wire
